/* hw/rtl/dsdz_pkg.sv */
package dsdz_pkg;

    typedef struct packed {
        logic [15:0]       buttons_now;
        logic signed [7:0] left_raw_x;
        logic signed [7:0] left_raw_y;
        logic signed [7:0] right_raw_x;
        logic signed [7:0] right_raw_y;
    } in_t;

    typedef struct packed {
        logic [15:0]        buttons_held;
        logic [15:0]        buttons_pressed;
        logic signed [7:0]  left_mirrored_x;
        logic signed [7:0]  left_mirrored_y;
        logic signed [7:0]  right_mirrored_x;
        logic signed [7:0]  right_mirrored_y;
        logic signed [15:0] left_out_x;
        logic signed [15:0] left_out_y;
        logic [14:0]        left_magnitude;
        logic signed [15:0] right_out_x;
        logic signed [15:0] right_out_y;
        logic [14:0]        right_magnitude;
    } out_t;

    typedef enum logic {
        OP_SQRT = 1'b0,
        OP_DIV  = 1'b1
    } op_t;

    typedef struct packed {
        logic        start;
        op_t         op;
        logic [14:0] radicand;
        logic [6:0]  numer;
        logic [7:0]  divisor;
    } unit_req_t;

    typedef struct packed {
        logic        done;
        logic [14:0] result;
    } unit_rsp_t;

    localparam int SQRT_STEPS = 8;
    localparam int DIV_STEPS  = 15;

    localparam logic signed [7:0] AXIS_MIN     = -8'sd128;
    localparam logic signed [7:0] AXIS_MAX     = 8'sd127;
    localparam logic signed [7:0] DZ_LIMIT     = 8'sd8;
    localparam logic signed [7:0] DZ_OFFSET    = 8'sd6;
    localparam logic [7:0]        CLAMP_RADIUS = 8'd64;
    localparam logic [14:0]       MAG_FULL     = 15'd16384;

    function automatic logic signed [7:0] mirror_axis(input logic signed [7:0] v);
        logic signed [7:0] r;
        if (v == AXIS_MIN) begin
            r = AXIS_MAX;
        end else begin
            r = -v;
        end
        return r;
    endfunction

    function automatic logic signed [7:0] dead_zone(input logic signed [7:0] v);
        logic signed [7:0] r;
        if (v <= -DZ_LIMIT) begin
            r = v + DZ_OFFSET;
        end else if (v >= DZ_LIMIT) begin
            r = v - DZ_OFFSET;
        end else begin
            r = 8'sd0;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/dsdz_sqdiv.sv */
module dsdz_sqdiv (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dsdz_pkg::unit_req_t  req,
    output dsdz_pkg::unit_rsp_t  rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    dsdz_pkg::op_t     op_reg, op_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [9:0]        rem_reg, rem_next;
    logic [14:0]       acc_reg, acc_next;
    logic [15:0]       sh_reg, sh_next;
    logic [7:0]        div_reg, div_next;

    logic [11:0]       a_op;
    logic [11:0]       b_op;
    logic [12:0]       diff;
    logic              ge;
    logic              last;

    // shared compare-subtract: one root digit or one quotient bit per cycle
    always_comb begin
        if (op_reg == dsdz_pkg::OP_SQRT) begin
            a_op = {rem_reg, sh_reg[15:14]};
            b_op = {2'b00, acc_reg[7:0], 2'b01};
            last = (cnt_reg == 4'(dsdz_pkg::SQRT_STEPS - 1));
        end else begin
            a_op = {3'b000, rem_reg[7:0], sh_reg[15]};
            b_op = {4'b0000, div_reg};
            last = (cnt_reg == 4'(dsdz_pkg::DIV_STEPS - 1));
        end
        diff = {1'b0, a_op} - {1'b0, b_op};
        ge   = ~diff[12];
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        div_next  = div_reg;
        if (req.start) begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = '0;
            acc_next  = '0;
            div_next  = req.divisor;
            if (req.op == dsdz_pkg::OP_SQRT) begin
                rem_next = '0;
                sh_next  = {1'b0, req.radicand};
            end else begin
                // numer <= divisor, so numer>>1 is already a valid partial remainder
                rem_next = {4'b0000, req.numer[6:1]};
                sh_next  = {req.numer[0], 15'b0};
            end
        end else if (busy_reg) begin
            rem_next = ge ? diff[9:0] : a_op[9:0];
            acc_next = {acc_reg[13:0], ge};
            cnt_next = cnt_reg + 4'd1;
            if (op_reg == dsdz_pkg::OP_SQRT) begin
                sh_next = {sh_reg[13:0], 2'b00};
            end else begin
                sh_next = {sh_reg[14:0], 1'b0};
            end
            if (last) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        div_reg <= div_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

/* hw/rtl/dual_stick_deadzone_radial_clamp.sv */
// Controller poll conditioner: button edge detect plus two stick pipelines
// (optional X mirror, dead zone, radial clamp to 64.0, signed Q7.8 out).
//
// Input channel s_valid/s_ready/s_data carries one poll word. Result channel
// m_valid/m_ready/m_data carries one result word per poll. cfg_wr_en with
// cfg_wr_data sets mirror_x at once; write it only while the block is idle.
//
// One poll is worked at a time. Each stick runs squarings of X then Y on one
// multiplier, an 8-step integer square root on the shared compare-subtract
// unit and, when the length exceeds 64, two 15-step divisions on that same
// unit. s_ready comes back together with m_valid, so a new poll is accepted
// only once the previous word has been loaded into the output register.
//
// If the receiver stalls, the finished word waits in the output register,
// the next poll may still be accepted and worked, and it is held back until
// the output register frees. Reset clears mirror_x, the previous button word,
// and m_valid, and returns the state to idle.
module dual_stick_deadzone_radial_clamp (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  dsdz_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output dsdz_pkg::out_t  m_data,
    input  logic            cfg_wr_en,
    input  logic            cfg_wr_data
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_SQX   = 10'b0000000010,
        ST_SQY   = 10'b0000000100,
        ST_ROOT  = 10'b0000001000,
        ST_WROOT = 10'b0000010000,
        ST_DIVX  = 10'b0000100000,
        ST_WDIVX = 10'b0001000000,
        ST_DIVY  = 10'b0010000000,
        ST_WDIVY = 10'b0100000000,
        ST_WB    = 10'b1000000000
    } state_t;

    state_t            state_reg, state_next;
    logic              mirror_reg, mirror_next;
    logic [15:0]       prev_reg, prev_next;
    logic              m_valid_reg, m_valid_next;
    dsdz_pkg::out_t    m_data_reg, m_data_next;
    dsdz_pkg::out_t    work_reg, work_next;
    logic              stick_reg, stick_next;
    logic signed [7:0] cx_reg [2];
    logic signed [7:0] cx_next [2];
    logic signed [7:0] cy_reg [2];
    logic signed [7:0] cy_next [2];
    logic [14:0]       sum_reg, sum_next;
    logic [7:0]        m_reg, m_next;

    logic signed [7:0]  lmx, rmx;
    logic signed [7:0]  cur_cx, cur_cy;
    logic signed [7:0]  mul_in;
    logic signed [15:0] prod;
    logic signed [7:0]  neg_x, neg_y;
    logic [6:0]         abs_x, abs_y;
    logic signed [15:0] qs;
    logic               finish;

    dsdz_pkg::unit_req_t u_req;
    dsdz_pkg::unit_rsp_t u_rsp;

    dsdz_sqdiv u_sqdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (u_req),
        .rsp     (u_rsp)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        lmx    = mirror_reg ? dsdz_pkg::mirror_axis(s_data.left_raw_x)  : s_data.left_raw_x;
        rmx    = mirror_reg ? dsdz_pkg::mirror_axis(s_data.right_raw_x) : s_data.right_raw_x;
        cur_cx = cx_reg[stick_reg];
        cur_cy = cy_reg[stick_reg];
        mul_in = (state_reg == ST_SQX) ? cur_cx : cur_cy;
        prod   = mul_in * mul_in;
        neg_x  = -cur_cx;
        neg_y  = -cur_cy;
        abs_x  = cur_cx[7] ? neg_x[6:0] : cur_cx[6:0];
        abs_y  = cur_cy[7] ? neg_y[6:0] : cur_cy[6:0];
        qs     = {1'b0, u_rsp.result};
    end

    always_comb begin
        u_req.start    = (state_reg == ST_ROOT) || (state_reg == ST_DIVX)
                         || (state_reg == ST_DIVY);
        u_req.op       = (state_reg == ST_ROOT) ? dsdz_pkg::OP_SQRT : dsdz_pkg::OP_DIV;
        u_req.radicand = sum_reg;
        u_req.numer    = (state_reg == ST_DIVY) ? abs_y : abs_x;
        u_req.divisor  = m_reg;
    end

    always_comb begin
        state_next   = state_reg;
        mirror_next  = cfg_wr_en ? cfg_wr_data : mirror_reg;
        prev_next    = prev_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        work_next    = work_reg;
        stick_next   = stick_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        sum_next     = sum_reg;
        m_next       = m_reg;
        finish       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    work_next.buttons_held     = s_data.buttons_now;
                    work_next.buttons_pressed  = s_data.buttons_now
                                                 & (s_data.buttons_now ^ prev_reg);
                    prev_next                  = s_data.buttons_now;
                    work_next.left_mirrored_x  = lmx;
                    work_next.left_mirrored_y  = s_data.left_raw_y;
                    work_next.right_mirrored_x = rmx;
                    work_next.right_mirrored_y = s_data.right_raw_y;
                    cx_next[0] = dsdz_pkg::dead_zone(lmx);
                    cy_next[0] = dsdz_pkg::dead_zone(s_data.left_raw_y);
                    cx_next[1] = dsdz_pkg::dead_zone(rmx);
                    cy_next[1] = dsdz_pkg::dead_zone(s_data.right_raw_y);
                    stick_next = 1'b0;
                    state_next = ST_SQX;
                end
            end
            ST_SQX: begin
                sum_next   = prod[14:0];
                state_next = ST_SQY;
            end
            ST_SQY: begin
                sum_next   = sum_reg + prod[14:0];
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                state_next = ST_WROOT;
            end
            ST_WROOT: begin
                if (u_rsp.done) begin
                    m_next = u_rsp.result[7:0];
                    if (u_rsp.result[7:0] > dsdz_pkg::CLAMP_RADIUS) begin
                        state_next = ST_DIVX;
                    end else begin
                        finish = 1'b1;
                        if (stick_reg) begin
                            work_next.right_out_x     = {cur_cx, 8'h00};
                            work_next.right_out_y     = {cur_cy, 8'h00};
                            work_next.right_magnitude = {u_rsp.result[6:0], 8'h00};
                        end else begin
                            work_next.left_out_x     = {cur_cx, 8'h00};
                            work_next.left_out_y     = {cur_cy, 8'h00};
                            work_next.left_magnitude = {u_rsp.result[6:0], 8'h00};
                        end
                    end
                end
            end
            ST_DIVX: begin
                state_next = ST_WDIVX;
            end
            ST_WDIVX: begin
                if (u_rsp.done) begin
                    if (stick_reg) begin
                        work_next.right_out_x = cur_cx[7] ? -qs : qs;
                    end else begin
                        work_next.left_out_x = cur_cx[7] ? -qs : qs;
                    end
                    state_next = ST_DIVY;
                end
            end
            ST_DIVY: begin
                state_next = ST_WDIVY;
            end
            ST_WDIVY: begin
                if (u_rsp.done) begin
                    finish = 1'b1;
                    if (stick_reg) begin
                        work_next.right_out_y     = cur_cy[7] ? -qs : qs;
                        work_next.right_magnitude = dsdz_pkg::MAG_FULL;
                    end else begin
                        work_next.left_out_y     = cur_cy[7] ? -qs : qs;
                        work_next.left_magnitude = dsdz_pkg::MAG_FULL;
                    end
                end
            end
            ST_WB: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = work_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish) begin
            if (stick_reg) begin
                state_next = ST_WB;
            end else begin
                stick_next = 1'b1;
                state_next = ST_SQX;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mirror_reg  <= 1'b0;
            prev_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mirror_reg  <= mirror_next;
            prev_reg    <= prev_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        work_reg   <= work_next;
        stick_reg  <= stick_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        sum_reg    <= sum_next;
        m_reg      <= m_next;
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a word while still working");

    a_done_when_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        u_rsp.done |-> (state_reg == ST_WROOT) || (state_reg == ST_WDIVX)
                       || (state_reg == ST_WDIVY))
        else $error("unit finished outside a wait state");

    a_div_only_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVX) || (state_reg == ST_DIVY)
        |-> m_reg > dsdz_pkg::CLAMP_RADIUS)
        else $error("division started for an unclamped length");

    a_mag_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.left_magnitude <= dsdz_pkg::MAG_FULL)
                    && (m_data.right_magnitude <= dsdz_pkg::MAG_FULL))
        else $error("magnitude above 64.0");
`endif

endmodule
